@@ rtl/hchacha_subkey_derivation_unit_defines.svh @@
// ----------------------------------------------------------------------------
// hchacha subkey derivation unit assertion macros
// shared forms for the concurrent checks of the top level
// ----------------------------------------------------------------------------
`ifndef HCHACHA_SUBKEY_DERIVATION_UNIT_DEFINES_SVH
`define HCHACHA_SUBKEY_DERIVATION_UNIT_DEFINES_SVH

// antecedent and consequent in the same cycle
`define HCSD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define HCSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hcsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcsd_pkg
// types and constants shared by the hchacha subkey derivation unit
// ----------------------------------------------------------------------------
package hcsd_pkg;

  localparam int WORD_W  = 32;
  localparam int FIELD_W = 64;
  localparam int ROUND_W = 5;
  localparam int DBL_W   = ROUND_W - 1;

  localparam logic [ROUND_W-1:0] ROUND_RESET = ROUND_W'(12);

  // "expand 32-byte k"
  localparam logic [WORD_W-1:0] SIGMA0 = 32'h61707865;
  localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320646e;
  localparam logic [WORD_W-1:0] SIGMA2 = 32'h79622d32;
  localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b206574;

  typedef logic [3:0][WORD_W-1:0] hcsd_row_t;
  typedef hcsd_row_t [3:0]        hcsd_matrix_t;

  typedef struct packed {
    logic [FIELD_W-1:0] key_w0;
    logic [FIELD_W-1:0] key_w1;
    logic [FIELD_W-1:0] key_w2;
    logic [FIELD_W-1:0] key_w3;
    logic [FIELD_W-1:0] nonce_lo;
    logic [FIELD_W-1:0] nonce_hi;
  } hcsd_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] subkey_w0;
    logic [FIELD_W-1:0] subkey_w1;
    logic [FIELD_W-1:0] subkey_w2;
    logic [FIELD_W-1:0] subkey_w3;
  } hcsd_out_t;

  // the four add-xor-rotate steps of a quarter round
  typedef enum logic [1:0] {
    QS_A16 = 2'd0,
    QS_C12 = 2'd1,
    QS_A8  = 2'd2,
    QS_C7  = 2'd3
  } hcsd_qstep_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } hcsd_fsm_t;

  typedef struct packed {
    logic        busy;
    logic        load;
    logic        run;
    logic        diag;
    hcsd_qstep_t step;
    logic        done;
  } hcsd_ctrl_t;

endpackage

@@ rtl/hcsd_qr_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcsd_qr_step
// one add-xor-rotate step of four quarter rounds side by side
// ----------------------------------------------------------------------------
module hcsd_qr_step (
  input  hcsd_pkg::hcsd_matrix_t mat,
  input  logic                   diag,
  input  hcsd_pkg::hcsd_qstep_t  step,
  output hcsd_pkg::hcsd_matrix_t mat_next
);

  logic [1:0]                  off1, off2, off3;
  logic [1:0]                  idx1 [4];
  logic [1:0]                  idx2 [4];
  logic [1:0]                  idx3 [4];
  logic [hcsd_pkg::WORD_W-1:0] va [4];
  logic [hcsd_pkg::WORD_W-1:0] vb [4];
  logic [hcsd_pkg::WORD_W-1:0] vc [4];
  logic [hcsd_pkg::WORD_W-1:0] vd [4];
  logic [hcsd_pkg::WORD_W-1:0] na [4];
  logic [hcsd_pkg::WORD_W-1:0] nb [4];
  logic [hcsd_pkg::WORD_W-1:0] nc [4];
  logic [hcsd_pkg::WORD_W-1:0] nd [4];
  logic [hcsd_pkg::WORD_W-1:0] tx [4];

  // diagonal rounds shift rows 1..3 left by their row number
  assign off1 = diag ? 2'd1 : 2'd0;
  assign off2 = diag ? 2'd2 : 2'd0;
  assign off3 = diag ? 2'd3 : 2'd0;

  always_comb begin
    mat_next = mat;
    for (int i = 0; i < 4; i++) begin
      idx1[i] = 2'(i) + off1;
      idx2[i] = 2'(i) + off2;
      idx3[i] = 2'(i) + off3;
      va[i] = mat[0][i];
      vb[i] = mat[1][idx1[i]];
      vc[i] = mat[2][idx2[i]];
      vd[i] = mat[3][idx3[i]];
      na[i] = va[i];
      nb[i] = vb[i];
      nc[i] = vc[i];
      nd[i] = vd[i];
      tx[i] = '0;
      case (step)
        hcsd_pkg::QS_A16: begin
          na[i] = va[i] + vb[i];
          tx[i] = vd[i] ^ na[i];
          nd[i] = {tx[i][15:0], tx[i][31:16]};
        end
        hcsd_pkg::QS_C12: begin
          nc[i] = vc[i] + vd[i];
          tx[i] = vb[i] ^ nc[i];
          nb[i] = {tx[i][19:0], tx[i][31:20]};
        end
        hcsd_pkg::QS_A8: begin
          na[i] = va[i] + vb[i];
          tx[i] = vd[i] ^ na[i];
          nd[i] = {tx[i][23:0], tx[i][31:24]};
        end
        hcsd_pkg::QS_C7: begin
          nc[i] = vc[i] + vd[i];
          tx[i] = vb[i] ^ nc[i];
          nb[i] = {tx[i][24:0], tx[i][31:25]};
        end
        default: begin
          tx[i] = '0;
        end
      endcase
    end
    // lanes map one to one onto columns, so the writes never collide
    for (int i = 0; i < 4; i++) begin
      mat_next[0][i]       = na[i];
      mat_next[1][idx1[i]] = nb[i];
      mat_next[2][idx2[i]] = nc[i];
      mat_next[3][idx3[i]] = nd[i];
    end
  end

endmodule

@@ rtl/hcsd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcsd_ctrl
// sequencer over steps, half rounds and double rounds
// ----------------------------------------------------------------------------
module hcsd_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [hcsd_pkg::DBL_W-1:0]   doubles,
  output hcsd_pkg::hcsd_ctrl_t         ctrl
);

  hcsd_pkg::hcsd_fsm_t        state, state_next;
  logic [1:0]                 step_cnt, step_cnt_next;
  logic                       diag, diag_next;
  logic [hcsd_pkg::DBL_W-1:0] dbl_cnt, dbl_cnt_next;
  logic [hcsd_pkg::DBL_W-1:0] target, target_next;
  logic                       load, run, done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= hcsd_pkg::ST_IDLE;
      step_cnt <= '0;
      diag     <= 1'b0;
      dbl_cnt  <= '0;
      target   <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
      diag     <= diag_next;
      dbl_cnt  <= dbl_cnt_next;
      target   <= target_next;
    end
  end

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    diag_next     = diag;
    dbl_cnt_next  = dbl_cnt;
    target_next   = target;
    load          = 1'b0;
    run           = 1'b0;
    done          = 1'b0;
    unique case (state)
      hcsd_pkg::ST_IDLE: begin
        if (start) begin
          load          = 1'b1;
          target_next   = doubles;
          step_cnt_next = '0;
          diag_next     = 1'b0;
          dbl_cnt_next  = '0;
          state_next    = (doubles == '0) ? hcsd_pkg::ST_DONE : hcsd_pkg::ST_RUN;
        end
      end
      hcsd_pkg::ST_RUN: begin
        run           = 1'b1;
        step_cnt_next = step_cnt + 2'd1;
        if (step_cnt == 2'd3) begin
          diag_next = !diag;
          if (diag) begin
            dbl_cnt_next = dbl_cnt + 1'b1;
            if (dbl_cnt_next == target) begin
              state_next = hcsd_pkg::ST_DONE;
            end
          end
        end
      end
      hcsd_pkg::ST_DONE: begin
        done       = 1'b1;
        state_next = hcsd_pkg::ST_IDLE;
      end
      default: begin
        state_next = hcsd_pkg::ST_IDLE;
      end
    endcase
  end

  assign ctrl.busy = (state != hcsd_pkg::ST_IDLE);
  assign ctrl.load = load;
  assign ctrl.run  = run;
  assign ctrl.diag = diag;
  assign ctrl.step = hcsd_pkg::hcsd_qstep_t'(step_cnt);
  assign ctrl.done = done;

endmodule

@@ rtl/hchacha_subkey_derivation_unit.sv @@
`timescale 1ns / 1ps
`include "hchacha_subkey_derivation_unit_defines.svh"
// ----------------------------------------------------------------------------
// hchacha_subkey_derivation_unit
// hchacha key derivation: 256-bit key and 128-bit nonce in, 256-bit subkey out
// ----------------------------------------------------------------------------
// A request transfer happens at the edge where start is high and busy is low.
// The unit then runs floor(round_count/2) chacha double rounds on a 4x4 word
// matrix and presents the subkey on the subkey port for exactly one cycle with
// done high; there is no backpressure, the receiver must take it then. One
// shared unit of four lanes does a single add-xor-rotate step of all four
// quarter rounds per cycle, four steps per column half and four per diagonal
// half. After acceptance the controller runs its run state, which is skipped
// when round_count is below two, then its done state, and then returns to
// idle; the next request can be taken once busy is low again (round_count
// resets to 12 rounds). busy stays high from acceptance through the done
// cycle. round_count is written through cfg_we/cfg_wdata and should only
// change while busy is low; odd counts lose their low bit and counts below
// two return the initial constants and nonce.
// ----------------------------------------------------------------------------
module hchacha_subkey_derivation_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  hcsd_pkg::hcsd_in_t            request,
  output logic                          done,
  output hcsd_pkg::hcsd_out_t           subkey,
  input  logic                          cfg_we,
  input  logic [hcsd_pkg::ROUND_W-1:0]  cfg_wdata
);

  logic [hcsd_pkg::ROUND_W-1:0] round_count;
  hcsd_pkg::hcsd_ctrl_t         ctrl;
  hcsd_pkg::hcsd_matrix_t       mat, mat_step, mat_init;

  // round count register, write only
  always_ff @(posedge clk) begin
    if (rst) begin
      round_count <= hcsd_pkg::ROUND_RESET;
    end else if (cfg_we) begin
      round_count <= cfg_wdata;
    end
  end

  hcsd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .doubles (round_count[hcsd_pkg::ROUND_W-1:1]),
    .ctrl    (ctrl)
  );

  // initial matrix: constants, key, nonce, low word of each field first
  always_comb begin
    mat_init[0][0] = hcsd_pkg::SIGMA0;
    mat_init[0][1] = hcsd_pkg::SIGMA1;
    mat_init[0][2] = hcsd_pkg::SIGMA2;
    mat_init[0][3] = hcsd_pkg::SIGMA3;
    mat_init[1][0] = request.key_w0[31:0];
    mat_init[1][1] = request.key_w0[63:32];
    mat_init[1][2] = request.key_w1[31:0];
    mat_init[1][3] = request.key_w1[63:32];
    mat_init[2][0] = request.key_w2[31:0];
    mat_init[2][1] = request.key_w2[63:32];
    mat_init[2][2] = request.key_w3[31:0];
    mat_init[2][3] = request.key_w3[63:32];
    mat_init[3][0] = request.nonce_lo[31:0];
    mat_init[3][1] = request.nonce_lo[63:32];
    mat_init[3][2] = request.nonce_hi[31:0];
    mat_init[3][3] = request.nonce_hi[63:32];
  end

  // shared quarter-round step unit, column or diagonal lane routing
  hcsd_qr_step u_qr_step (
    .mat      (mat),
    .diag     (ctrl.diag),
    .step     (ctrl.step),
    .mat_next (mat_step)
  );

  // working matrix, payload only
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mat <= mat_init;
    end else if (ctrl.run) begin
      mat <= mat_step;
    end
  end

  // matrix holds still during the done cycle, so rows 0 and 3 feed the port
  assign busy             = ctrl.busy;
  assign done             = ctrl.done;
  assign subkey.subkey_w0 = {mat[0][1], mat[0][0]};
  assign subkey.subkey_w1 = {mat[0][3], mat[0][2]};
  assign subkey.subkey_w2 = {mat[3][1], mat[3][0]};
  assign subkey.subkey_w3 = {mat[3][3], mat[3][2]};

  // checks
  `HCSD_ASSERT_SAME(a_done_while_busy, clk, rst, done, busy, "done outside busy")
  `HCSD_ASSERT_NEXT(a_accept_sets_busy, clk, rst, start && !busy, busy, "transfer left idle")
  `HCSD_ASSERT_NEXT(a_done_one_cycle, clk, rst, done, !done, "done longer than one cycle")
  `HCSD_ASSERT_NEXT(a_run_stays_busy, clk, rst, busy && !done, busy, "busy dropped before done")

endmodule
